### hdl/assert_macros.svh
// assertion macros used by the alu core
// needs a clock named clk and an active-low reset named arst_n in scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising edge, off while in reset
`define ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// same-cycle implication
`define ASSERT_IMPL(label, ante, cons, msg) \
	`ASSERT_CLK(label, (ante) |-> (cons), msg)

// next-cycle implication
`define ASSERT_NEXT(label, ante, cons, msg) \
	`ASSERT_CLK(label, (ante) |=> (cons), msg)

`endif

### hdl/iasf_pkg.sv
// types, codes and helper functions for the integer alu with status flags
// no dependencies
package iasf_pkg;

	localparam int W     = 32;
	localparam int DW    = 2 * W;
	localparam int CNT_W = 7;

	// operation codes
	localparam logic [3:0] OP_ADD  = 4'd0;
	localparam logic [3:0] OP_ADC  = 4'd1;
	localparam logic [3:0] OP_SUB  = 4'd2;
	localparam logic [3:0] OP_SBB  = 4'd3;
	localparam logic [3:0] OP_MUL  = 4'd4;
	localparam logic [3:0] OP_IMUL = 4'd5;
	localparam logic [3:0] OP_DIV  = 4'd6;
	localparam logic [3:0] OP_IDIV = 4'd7;
	localparam logic [3:0] OP_MOD  = 4'd8;
	localparam logic [3:0] OP_IMOD = 4'd9;
	localparam logic [3:0] OP_AND  = 4'd10;
	localparam logic [3:0] OP_XOR  = 4'd11;
	localparam logic [3:0] OP_OR   = 4'd12;
	localparam logic [3:0] OP_SHL  = 4'd13;
	localparam logic [3:0] OP_SHR  = 4'd14;
	localparam logic [3:0] OP_SAR  = 4'd15;

	// operand size codes
	localparam logic [1:0] SZ_8  = 2'd0;
	localparam logic [1:0] SZ_16 = 2'd1;

	typedef struct packed {
		logic [3:0]   opcode;
		logic [1:0]   operand_size;
		logic [W-1:0] source_operand;
		logic [W-1:0] dest_low;
		logic [W-1:0] dest_high;
	} in_req_t;

	typedef struct packed {
		logic [W-1:0] result_low;
		logic [W-1:0] result_high;
		logic         carry_out;
		logic         parity_out;
		logic         zero_out;
		logic         sign_out;
		logic         overflow_out;
		logic         divide_by_zero;
	} out_req_t;

	typedef struct packed {
		logic cf;
		logic pf;
		logic zf;
		logic sf;
		logic of;
	} flags_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PREP,
		ST_ITER,
		ST_FIX,
		ST_DONE
	} state_t;

	// sequencer strobes towards the datapath
	typedef struct packed {
		logic idle;
		logic prep;
		logic iter;
		logic fix;
		logic done;
	} ctrl_t;

	function automatic logic [W-1:0] size_mask(logic [1:0] sz);
		logic [W-1:0] m;
		case (sz)
			SZ_8:    m = 32'h0000_00FF;
			SZ_16:   m = 32'h0000_FFFF;
			default: m = 32'hFFFF_FFFF;
		endcase
		return m;
	endfunction

	function automatic logic msb_of(logic [W-1:0] v, logic [1:0] sz);
		logic b;
		case (sz)
			SZ_8:    b = v[7];
			SZ_16:   b = v[15];
			default: b = v[W-1];
		endcase
		return b;
	endfunction

	function automatic logic [W-1:0] sext_w(logic [W-1:0] v, logic [1:0] sz);
		logic [W-1:0] r;
		case (sz)
			SZ_8:    r = {{(W-8){v[7]}}, v[7:0]};
			SZ_16:   r = {{(W-16){v[15]}}, v[15:0]};
			default: r = v;
		endcase
		return r;
	endfunction

	// sign, zero and parity from a result, carry and overflow cleared
	function automatic flags_t szp(logic [W-1:0] r, logic [1:0] sz);
		flags_t f;
		f    = '0;
		f.pf = ~^r[7:0];
		f.zf = (r & size_mask(sz)) == '0;
		f.sf = msb_of(r, sz);
		return f;
	endfunction

endpackage

### hdl/iasf_addsub.sv
// shared 33-bit adder/subtractor used by add, sub, multiply and divide steps
// depends on iasf_pkg
module iasf_addsub
	import iasf_pkg::*;
(
	input  logic [W:0] a,
	input  logic [W:0] b,
	input  logic       sub,
	input  logic       ci,
	output logic [W:0] y
);

	// invert b for subtraction, carry in supplied by the caller
	assign y = a + (sub ? ~b : b) + {{W{1'b0}}, ci};

endmodule

### hdl/iasf_ctrl.sv
// sequencer for the alu: idle, prepare, iterate, fix-up, result held
// depends on iasf_pkg
module iasf_ctrl
	import iasf_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic             go_iter,
	input  logic [CNT_W-1:0] iter_len,
	input  logic             taken,
	output ctrl_t            ctrl
);

	state_t           state_q, state_d;
	logic [CNT_W-1:0] cnt_q;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: if (start) state_d = ST_PREP;
			ST_PREP: state_d = go_iter ? ST_ITER : ST_DONE;
			ST_ITER: if (cnt_q == CNT_W'(1)) state_d = ST_FIX;
			ST_FIX:  state_d = ST_DONE;
			ST_DONE: if (taken) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// strobes
	always_comb begin
		ctrl = '0;
		unique case (state_q)
			ST_IDLE: ctrl.idle = 1'b1;
			ST_PREP: ctrl.prep = 1'b1;
			ST_ITER: ctrl.iter = 1'b1;
			ST_FIX:  ctrl.fix  = 1'b1;
			ST_DONE: ctrl.done = 1'b1;
			default: ctrl      = '0;
		endcase
	end

	// state and step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_PREP) begin
				cnt_q <= iter_len;
			end else if (state_q == ST_ITER) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
		end
	end

endmodule

### hdl/integer_alu_with_status_flags_core.sv
// Integer alu with x86 status flags. One request is taken while idle and its result is
// held on the output until taken; no new request is accepted meanwhile. Add, adc, sub,
// sbb, logic ops, shifts and a zero divisor show their result right after the prepare state.
// Mul and imul go through prepare, 32 shift-add steps and fix-up; div, idiv, mod and imod
// go through prepare, one shift-subtract step per dividend bit and fix-up. Every multiply
// and divide step goes through one shared 33-bit adder, one product or quotient bit per
// cycle. After the result is taken the block returns to idle in the next cycle.
// Carry, parity, zero, sign and overflow are kept between requests.
// depends on iasf_pkg, iasf_ctrl, iasf_addsub and assert_macros.svh
`include "assert_macros.svh"

module integer_alu_with_status_flags_core
	import iasf_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_stall,
	input  in_req_t  in_data,
	output logic     out_valid,
	input  logic     out_stall,
	output out_req_t out_data
);

	ctrl_t            ctrl;
	logic             accept;
	logic             go_iter;
	logic [CNT_W-1:0] iter_len;

	// captured request
	logic [3:0]    op_q;
	logic [1:0]    sz_q;
	logic [W-1:0]  s_q, d_q, h_q;
	logic [4:0]    shamt_q;
	flags_t        flags_q;

	// iteration registers
	logic [W-1:0]  acc_q;
	logic [DW-1:0] dvd_q;
	logic [W-1:0]  opb_q;
	logic          neg_q, rneg_q;
	out_req_t      out_q;

	// shared unit
	logic [W:0]    unit_a, unit_b, unit_y;
	logic          unit_sub, unit_ci;

	// decode and prep
	logic [W-1:0]  m, res, abs_s, abs_d, sx_s, sx_d;
	logic          sd, ss, is_sub, cin_use, signed_op, is_mul, is_div, c, ov;
	flags_t        f_new;
	logic [DW-1:0] shl_t, dv_u, dv_s, dv_abs, dv_sel, dv_align;
	logic [W:0]    shr_t;
	logic signed [W:0] sar_in, sar_t;

	// step and fix
	logic [W:0]    mul_sum, div_shift;
	logic [W-1:0]  acc_next;
	logic [DW-1:0] dvd_next;
	logic [DW-1:0] prod, prod_fix;
	logic [W-1:0]  fix_lo, fix_hi, q_fix, r_fix;
	logic          fix_c;
	flags_t        f_fix;

	assign accept    = in_valid & ~in_stall;
	assign in_stall  = ~ctrl.idle;
	assign out_valid = ctrl.done;
	assign out_data  = out_q;

	iasf_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (accept),
		.go_iter  (go_iter),
		.iter_len (iter_len),
		.taken    (ctrl.done & ~out_stall),
		.ctrl     (ctrl)
	);

	iasf_addsub u_addsub (
		.a   (unit_a),
		.b   (unit_b),
		.sub (unit_sub),
		.ci  (unit_ci),
		.y   (unit_y)
	);

	// operation decode
	always_comb begin
		m         = size_mask(sz_q);
		sd        = msb_of(d_q, sz_q);
		ss        = msb_of(s_q, sz_q);
		is_sub    = (op_q == OP_SUB) || (op_q == OP_SBB);
		cin_use   = ((op_q == OP_ADC) || (op_q == OP_SBB)) & flags_q.cf;
		signed_op = (op_q == OP_IMUL) || (op_q == OP_IDIV) || (op_q == OP_IMOD);
		is_mul    = (op_q == OP_MUL) || (op_q == OP_IMUL);
		is_div    = (op_q == OP_DIV) || (op_q == OP_IDIV) || (op_q == OP_MOD) ||
			(op_q == OP_IMOD);
		go_iter   = is_mul || (is_div && (s_q != '0));
		if (is_mul) begin
			iter_len = CNT_W'(W);
		end else begin
			case (sz_q)
				SZ_8:    iter_len = CNT_W'(16);
				SZ_16:   iter_len = CNT_W'(32);
				default: iter_len = CNT_W'(DW);
			endcase
		end
	end

	// shared unit operand selection
	always_comb begin
		unit_a   = {1'b0, d_q};
		unit_b   = {1'b0, s_q};
		unit_sub = is_sub;
		unit_ci  = is_sub ? ~cin_use : cin_use;
		if (ctrl.iter) begin
			unit_b = {1'b0, opb_q};
			if (is_mul) begin
				unit_a   = {1'b0, acc_q};
				unit_sub = 1'b0;
				unit_ci  = 1'b0;
			end else begin
				unit_a   = {acc_q, dvd_q[DW-1]};
				unit_sub = 1'b1;
				unit_ci  = 1'b1;
			end
		end
	end

	// non-iterative results and multiply/divide setup
	always_comb begin
		res    = '0;
		c      = 1'b0;
		ov     = 1'b0;
		f_new  = flags_q;
		shl_t  = {{W{1'b0}}, d_q} << shamt_q;
		shr_t  = {d_q, 1'b0} >> shamt_q;
		sx_d   = sext_w(d_q, sz_q);
		sx_s   = sext_w(s_q, sz_q);
		sar_in = {sx_d, 1'b0};
		sar_t  = sar_in >>> shamt_q;
		abs_s  = ss ? (~sx_s + W'(1)) : sx_s;
		abs_d  = sd ? (~sx_d + W'(1)) : sx_d;
		case (sz_q)
			SZ_8: begin
				dv_u = {{(DW-16){1'b0}}, h_q[7:0], d_q[7:0]};
				dv_s = {{(DW-16){h_q[7]}}, h_q[7:0], d_q[7:0]};
			end
			SZ_16: begin
				dv_u = {{(DW-32){1'b0}}, h_q[15:0], d_q[15:0]};
				dv_s = {{(DW-32){h_q[15]}}, h_q[15:0], d_q[15:0]};
			end
			default: begin
				dv_u = {h_q, d_q};
				dv_s = {h_q, d_q};
			end
		endcase
		dv_abs = dv_s[DW-1] ? (~dv_s + DW'(1)) : dv_s;
		dv_sel = signed_op ? dv_abs : dv_u;
		case (sz_q)
			SZ_8:    dv_align = {dv_sel[15:0], {(DW-16){1'b0}}};
			SZ_16:   dv_align = {dv_sel[31:0], {(DW-32){1'b0}}};
			default: dv_align = dv_sel;
		endcase

		case (op_q) inside
			OP_ADD, OP_ADC, OP_SUB, OP_SBB: begin
				res = unit_y[W-1:0] & m;
				if (is_sub) begin
					c  = unit_y[W];
					ov = (sd != ss) && (msb_of(res, sz_q) != sd);
				end else begin
					case (sz_q)
						SZ_8:    c = unit_y[8];
						SZ_16:   c = unit_y[16];
						default: c = unit_y[W];
					endcase
					ov = (sd == ss) && (msb_of(res, sz_q) != sd);
				end
				f_new    = szp(res, sz_q);
				f_new.cf = c;
				f_new.of = ov;
			end
			OP_AND, OP_XOR, OP_OR: begin
				if (op_q == OP_AND) begin
					res = d_q & s_q;
				end else if (op_q == OP_XOR) begin
					res = d_q ^ s_q;
				end else begin
					res = d_q | s_q;
				end
				f_new = szp(res, sz_q);
			end
			OP_SHL, OP_SHR, OP_SAR: begin
				if (shamt_q == '0) begin
					res = d_q;
				end else begin
					if (op_q == OP_SHL) begin
						res = shl_t[W-1:0] & m;
						case (sz_q)
							SZ_8:    c = shl_t[8];
							SZ_16:   c = shl_t[16];
							default: c = shl_t[W];
						endcase
						ov = msb_of(res, sz_q) ^ c;
					end else if (op_q == OP_SHR) begin
						res = shr_t[W:1];
						c   = shr_t[0];
						ov  = sd;
					end else begin
						res = sar_t[W:1] & m;
						c   = sar_t[0];
					end
					f_new    = szp(res, sz_q);
					f_new.cf = c;
					f_new.of = ov;
				end
			end
			default: begin
				res   = '0;
				f_new = flags_q;
			end
		endcase
	end

	// one multiply or divide step
	always_comb begin
		mul_sum   = dvd_q[0] ? unit_y : {1'b0, acc_q};
		div_shift = {acc_q, dvd_q[DW-1]};
		if (is_mul) begin
			acc_next = mul_sum[W:1];
			dvd_next = {dvd_q[DW-1:W], mul_sum[0], dvd_q[W-1:1]};
		end else if (!unit_y[W]) begin
			acc_next = unit_y[W-1:0];
			dvd_next = {dvd_q[DW-2:0], 1'b1};
		end else begin
			acc_next = div_shift[W-1:0];
			dvd_next = {dvd_q[DW-2:0], 1'b0};
		end
	end

	// sign fix-up and multiply flags
	always_comb begin
		prod     = {acc_q, dvd_q[W-1:0]};
		prod_fix = neg_q ? (~prod + DW'(1)) : prod;
		fix_lo   = prod_fix[W-1:0] & m;
		case (sz_q)
			SZ_8:    fix_hi = {{(W-8){1'b0}}, prod_fix[15:8]};
			SZ_16:   fix_hi = {{(W-16){1'b0}}, prod_fix[31:16]};
			default: fix_hi = prod_fix[DW-1:W];
		endcase
		if (op_q == OP_IMUL) begin
			fix_c = fix_hi != (msb_of(fix_lo, sz_q) ? m : '0);
		end else begin
			fix_c = fix_hi != '0;
		end
		f_fix    = szp(fix_lo, sz_q);
		f_fix.cf = fix_c;
		f_fix.of = fix_c;
		q_fix    = neg_q ? (~dvd_q[W-1:0] + W'(1)) : dvd_q[W-1:0];
		r_fix    = rneg_q ? (~acc_q + W'(1)) : acc_q;
	end

	// status flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flags_q <= '0;
		end else if (ctrl.prep && !is_mul && !is_div) begin
			flags_q <= f_new;
		end else if (ctrl.fix && is_mul) begin
			flags_q <= f_fix;
		end
	end

	// request capture, iteration and result registers
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q    <= in_data.opcode;
			sz_q    <= in_data.operand_size;
			s_q     <= in_data.source_operand & size_mask(in_data.operand_size);
			d_q     <= in_data.dest_low & size_mask(in_data.operand_size);
			h_q     <= in_data.dest_high & size_mask(in_data.operand_size);
			shamt_q <= in_data.source_operand[4:0];
		end
		if (ctrl.prep) begin
			out_q.result_low     <= res;
			out_q.result_high    <= '0;
			out_q.carry_out      <= f_new.cf;
			out_q.parity_out     <= f_new.pf;
			out_q.zero_out       <= f_new.zf;
			out_q.sign_out       <= f_new.sf;
			out_q.overflow_out   <= f_new.of;
			out_q.divide_by_zero <= is_div && (s_q == '0);
			acc_q                <= '0;
			if (is_mul) begin
				dvd_q  <= {{W{1'b0}}, (signed_op ? abs_d : d_q)};
				opb_q  <= signed_op ? abs_s : s_q;
				neg_q  <= signed_op & (sd ^ ss);
				rneg_q <= 1'b0;
			end else begin
				dvd_q  <= dv_align;
				opb_q  <= signed_op ? abs_s : s_q;
				neg_q  <= signed_op & (dv_s[DW-1] ^ ss);
				rneg_q <= signed_op & dv_s[DW-1];
			end
		end
		if (ctrl.iter) begin
			acc_q <= acc_next;
			dvd_q <= dvd_next;
		end
		if (ctrl.fix) begin
			if (is_mul) begin
				out_q.result_low   <= fix_lo;
				out_q.result_high  <= fix_hi;
				out_q.carry_out    <= f_fix.cf;
				out_q.parity_out   <= f_fix.pf;
				out_q.zero_out     <= f_fix.zf;
				out_q.sign_out     <= f_fix.sf;
				out_q.overflow_out <= f_fix.of;
			end else begin
				if ((op_q == OP_DIV) || (op_q == OP_IDIV)) begin
					out_q.result_low <= q_fix & m;
				end else begin
					out_q.result_low <= r_fix & m;
				end
				out_q.result_high  <= '0;
				out_q.carry_out    <= flags_q.cf;
				out_q.parity_out   <= flags_q.pf;
				out_q.zero_out     <= flags_q.zf;
				out_q.sign_out     <= flags_q.sf;
				out_q.overflow_out <= flags_q.of;
			end
			out_q.divide_by_zero <= 1'b0;
		end
	end

	// checks
	`ASSERT_IMPL(a_no_req_while_result, out_valid, in_stall, "request taken while result held")
	`ASSERT_NEXT(a_accept_no_result, accept, !out_valid, "result shown right after accept")
	`ASSERT_IMPL(a_dz_zero_result, out_valid && out_data.divide_by_zero,
		out_data.result_low == '0, "zero divisor gave nonzero result")

endmodule
